>>> hdl/escape_sequence_decoder_defines.svh
// ----------------------------------------------------------------------------
// Escape sequence decoder assertion macros
// Shared assertion shorthands for the escape sequence decoder.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ESD_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("escape decoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define ESD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("escape decoder: next-cycle check failed");

`endif

>>> hdl/esd_pkg.sv
// ----------------------------------------------------------------------------
// Escape sequence decoder package
// Types, character constants and lookup functions for the decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

  localparam int CharW = 21;
  localparam int TokW  = 24;
  localparam int MaxHexDigitsDefault = 6;

  typedef enum logic [2:0] {
    MODE_READY     = 3'd0,
    MODE_ESC       = 3'd1,
    MODE_U         = 3'd2,
    MODE_PAYLOAD   = 3'd3,
    MODE_ERR_START = 3'd4,
    MODE_ERR_LEN   = 3'd5,
    MODE_ERR_HEX   = 3'd6
  } mode_t;

  localparam logic [CharW-1:0] ChBackslash = CharW'(8'h5C);
  localparam logic [CharW-1:0] ChLowerU    = CharW'(8'h75);
  localparam logic [CharW-1:0] ChOpenBrace = CharW'(8'h7B);
  localparam logic [CharW-1:0] ChCloseBrace = CharW'(8'h7D);
  localparam logic [7:0]       CtrlEscape  = 8'h1B;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  // Value of a hex digit in either case; ok is low for any other character.
  function automatic hex_digit_t hex_value(logic [CharW-1:0] c);
    hex_digit_t r;
    r = '0;
    if (c >= CharW'(8'h30) && c <= CharW'(8'h39)) begin
      r.ok    = 1'b1;
      r.value = 4'(c - CharW'(8'h30));
    end else if (c >= CharW'(8'h61) && c <= CharW'(8'h66)) begin
      r.ok    = 1'b1;
      r.value = 4'(c - CharW'(8'h61) + CharW'(10));
    end else if (c >= CharW'(8'h41) && c <= CharW'(8'h46)) begin
      r.ok    = 1'b1;
      r.value = 4'(c - CharW'(8'h41) + CharW'(10));
    end
    return r;
  endfunction

  // Control character for a simple escape letter, zero when there is none.
  function automatic logic [7:0] simple_escape(logic [CharW-1:0] c);
    logic [7:0] r;
    r = 8'h00;
    if (c[CharW-1:8] == '0) begin
      case (c[7:0])
        8'h61:   r = 8'h07;
        8'h62:   r = 8'h08;
        8'h65:   r = CtrlEscape;
        8'h66:   r = 8'h0C;
        8'h6E:   r = 8'h0A;
        8'h72:   r = 8'h0D;
        8'h74:   r = 8'h09;
        8'h76:   r = 8'h0B;
        8'h5C:   r = 8'h5C;
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

endpackage

>>> hdl/escape_sequence_decoder.sv
// ----------------------------------------------------------------------------
// Escape sequence decoder
// Decodes backslash escapes and braced hex codepoints in a character stream.
// ----------------------------------------------------------------------------
// The decoder takes one codepoint per beat and returns exactly one result
// beat for every input beat, in order. A plain character is a token by
// itself. A backslash followed by a, b, e, f, n, r, t, v or a second
// backslash yields the matching control character, a backslash followed by
// u{...} yields the hex value of up to MAX_HEX_DIGITS digits (either case,
// an empty pair gives zero), and any other escaped character is passed
// through with the escaped flag set. A malformed u escape drives the block
// into one of three error modes that hold until reset; later beats still
// produce results, reporting the error mode with no token. The block
// sustains one beat per clock cycle while the result side accepts; a
// result beat passes through an input register, then one pass of decode
// logic into the result register. The rate is set by the mode, digit count
// and accumulator feedback loop. The input side keeps accepting while a
// result waits, as long as the result register can move on in the same
// cycle. No beat is accepted while reset is high.

`include "escape_sequence_decoder_defines.svh"

module escape_sequence_decoder
  import esd_pkg::*;
#(
  parameter int MAX_HEX_DIGITS = MaxHexDigitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [TokW-1:0]     s_axis_tdata,   // [20:0] char_in, [23:21] zero
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [TokW-1:0]     m_axis_tdata,   // [23:0] token_char
  output logic [7:0]          m_axis_tuser    // [2:0] mode_code, [3] token_valid,
                                              // [4] escaped_flag, [7:5] zero
);

  localparam int CountW = $clog2(MAX_HEX_DIGITS + 1);
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_HEX_DIGITS);

  // Input register.
  logic             in_valid;
  logic [CharW-1:0] in_char;

  // Decoder state.
  mode_t             mode, mode_next;
  logic [CountW-1:0] digit_count, digit_count_next;
  logic [TokW-1:0]   hex_accum, hex_accum_next;

  // Result register.
  logic            out_valid;
  mode_t           out_mode;
  logic            out_token_valid;
  logic [TokW-1:0] out_token_char;
  logic            out_escaped;

  // Per-beat decode results.
  logic            tok_valid;
  logic [TokW-1:0] tok_char;
  logic            tok_esc;
  logic [7:0]      esc_map;
  hex_digit_t      hex_d;

  logic advance;

  // The decode stage moves when it holds a beat and the result register is
  // free or being emptied this cycle.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !rst && (!in_valid || advance);

  assign esc_map = simple_escape(in_char);
  assign hex_d   = hex_value(in_char);

  // Next mode.
  always_comb begin
    mode_next = mode;
    unique case (mode)
      MODE_READY: begin
        if (in_char == ChBackslash) begin
          mode_next = MODE_ESC;
        end
      end
      MODE_ESC: begin
        if (esc_map == 8'h00 && in_char == ChLowerU) begin
          mode_next = MODE_U;
        end else begin
          mode_next = MODE_READY;
        end
      end
      MODE_U: begin
        mode_next = (in_char == ChOpenBrace) ? MODE_PAYLOAD : MODE_ERR_START;
      end
      MODE_PAYLOAD: begin
        if (in_char == ChCloseBrace) begin
          mode_next = MODE_READY;
        end else if (digit_count >= MaxCount) begin
          mode_next = MODE_ERR_LEN;
        end else if (!hex_d.ok) begin
          mode_next = MODE_ERR_HEX;
        end
      end
      default: begin
        mode_next = mode;
      end
    endcase
  end

  // Token, count and accumulator.
  always_comb begin
    tok_valid        = 1'b0;
    tok_char         = '0;
    tok_esc          = 1'b0;
    digit_count_next = digit_count;
    hex_accum_next   = hex_accum;
    unique case (mode)
      MODE_READY: begin
        if (in_char != ChBackslash) begin
          tok_valid = 1'b1;
          tok_char  = TokW'(in_char);
        end
      end
      MODE_ESC: begin
        if (esc_map != 8'h00) begin
          tok_valid = 1'b1;
          tok_char  = TokW'(esc_map);
        end else if (in_char != ChLowerU) begin
          tok_valid = 1'b1;
          tok_char  = TokW'(in_char);
          tok_esc   = 1'b1;
        end
      end
      MODE_U: begin
        if (in_char == ChOpenBrace) begin
          digit_count_next = '0;
          hex_accum_next   = '0;
        end
      end
      MODE_PAYLOAD: begin
        if (in_char == ChCloseBrace) begin
          tok_valid = 1'b1;
          tok_char  = hex_accum;
        end else if (digit_count < MaxCount) begin
          digit_count_next = digit_count + CountW'(1);
          if (hex_d.ok) begin
            hex_accum_next = {hex_accum[TokW-5:0], hex_d.value};
          end
        end
      end
      default: begin
        tok_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
      mode        <= MODE_READY;
      digit_count <= '0;
      hex_accum   <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid   <= 1'b1;
        mode        <= mode_next;
        digit_count <= digit_count_next;
        hex_accum   <= hex_accum_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata[CharW-1:0];
    end
    if (advance) begin
      out_mode        <= mode_next;
      out_token_valid <= tok_valid;
      out_token_char  <= tok_char;
      out_escaped     <= tok_esc;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_token_char;
  assign m_axis_tuser  = {3'b000, out_escaped, out_token_valid, out_mode};

  // Error modes never leave until reset.
  `ESD_ASSERT_NEXT(a_err_sticky, mode >= MODE_ERR_START, $stable(mode))
  // Every completed token returns the decoder to the ready mode.
  `ESD_ASSERT_IMPLIES(a_tok_ready, out_valid && out_token_valid, out_mode == MODE_READY)
  // A literal pass-through is always a token.
  `ESD_ASSERT_IMPLIES(a_esc_tok, out_valid && out_escaped, out_token_valid)
  // The digit count never runs past the payload limit.
  `ESD_ASSERT_IMPLIES(a_count_max, 1'b1, digit_count <= MaxCount)

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// Escape sequence decoder testbench
// Drives codepoint beats into the decoder and checks every result beat
// against an in-bench model of the escape decoding, with random idling on
// both stream sides.
// ----------------------------------------------------------------------------
// A short directed table comes first. Rows whose result is obvious carry a
// typed expectation; the rest are predicted. Random well-formed sequences
// follow: plain characters, simple escapes, unknown escapes and braced hex
// escapes of every length. Error modes hold until reset, and reset happens
// once, so the run ends with one broken u escape of a randomly chosen kind
// and a tail of noise beats that must all report the sticky error.

module tb;
  import esd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxDigits  = MaxHexDigitsDefault;
  localparam int CycleLimit = 1_000_000;
  localparam int RandomBeats = 1900;
  localparam int TailBeats  = 40;

  typedef struct {
    mode_t       mode;
    bit          valid;
    logic [23:0] tok;
    bit          esc;
  } token_t;

  typedef struct {
    logic [20:0] ch;
    bit          typed;
    token_t      want;
  } dir_row_t;

  typedef enum int {
    BREAK_START,
    BREAK_LEN,
    BREAK_HEX
  } break_kind_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [TokW-1:0] s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [TokW-1:0] m_axis_tdata;
  logic [7:0]      m_axis_tuser;

  // Decoder state as the bench sees it.
  mode_t       dec_mode   = MODE_READY;
  int          dec_digits = 0;
  logic [23:0] dec_accum  = '0;

  token_t token_queue[$];
  int     fail_count = 0;
  int     item_count = 0;
  int     cycle_count = 0;
  bit     tx_burst = 1'b0;
  bit     rx_burst = 1'b0;

  localparam logic [20:0] EscLetters [9] = '{
    21'h61, 21'h62, 21'h65, 21'h66, 21'h6E, 21'h72, 21'h74, 21'h76, 21'h5C
  };

  // Directed rows. Backslash rows that only open an escape report the
  // after-backslash mode with no token.
  dir_row_t dir_table [25] = '{
    '{21'h000041, 1'b1, '{MODE_READY,   1'b1, 24'h000041, 1'b0}},
    '{21'h000000, 1'b1, '{MODE_READY,   1'b1, 24'h000000, 1'b0}},
    '{21'h10FFFF, 1'b1, '{MODE_READY,   1'b1, 24'h10FFFF, 1'b0}},
    '{21'h00005C, 1'b1, '{MODE_ESC,     1'b0, 24'h000000, 1'b0}},
    '{21'h000061, 1'b1, '{MODE_READY,   1'b1, 24'h000007, 1'b0}},
    '{21'h00005C, 1'b1, '{MODE_ESC,     1'b0, 24'h000000, 1'b0}},
    '{21'h000065, 1'b1, '{MODE_READY,   1'b1, 24'h00001B, 1'b0}},
    '{21'h00005C, 1'b1, '{MODE_ESC,     1'b0, 24'h000000, 1'b0}},
    '{21'h00005C, 1'b1, '{MODE_READY,   1'b1, 24'h00005C, 1'b0}},
    '{21'h00005C, 1'b1, '{MODE_ESC,     1'b0, 24'h000000, 1'b0}},
    '{21'h000076, 1'b1, '{MODE_READY,   1'b1, 24'h00000B, 1'b0}},
    '{21'h00005C, 1'b1, '{MODE_ESC,     1'b0, 24'h000000, 1'b0}},
    '{21'h000075, 1'b1, '{MODE_U,       1'b0, 24'h000000, 1'b0}},
    '{21'h00007B, 1'b1, '{MODE_PAYLOAD, 1'b0, 24'h000000, 1'b0}},
    '{21'h00007D, 1'b1, '{MODE_READY,   1'b1, 24'h000000, 1'b0}},
    '{21'h00005C, 1'b1, '{MODE_ESC,     1'b0, 24'h000000, 1'b0}},
    '{21'h000078, 1'b1, '{MODE_READY,   1'b1, 24'h000078, 1'b1}},
    '{21'h00005C, 1'b1, '{MODE_ESC,     1'b0, 24'h000000, 1'b0}},
    '{21'h000000, 1'b1, '{MODE_READY,   1'b1, 24'h000000, 1'b1}},
    '{21'h00005C, 1'b0, '{MODE_READY,   1'b0, 24'h000000, 1'b0}},
    '{21'h000075, 1'b0, '{MODE_READY,   1'b0, 24'h000000, 1'b0}},
    '{21'h00007B, 1'b0, '{MODE_READY,   1'b0, 24'h000000, 1'b0}},
    '{21'h000061, 1'b0, '{MODE_READY,   1'b0, 24'h000000, 1'b0}},
    '{21'h000046, 1'b0, '{MODE_READY,   1'b0, 24'h000000, 1'b0}},
    '{21'h00007D, 1'b0, '{MODE_READY,   1'b0, 24'h000000, 1'b0}}
  };

  escape_sequence_decoder #(
    .MAX_HEX_DIGITS(MaxDigits)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Control character for a simple escape letter, zero for anything else.
  function automatic logic [23:0] escape_code(logic [20:0] c);
    case (c)
      21'h61:  return 24'h07;
      21'h62:  return 24'h08;
      21'h65:  return 24'h1B;
      21'h66:  return 24'h0C;
      21'h6E:  return 24'h0A;
      21'h72:  return 24'h0D;
      21'h74:  return 24'h09;
      21'h76:  return 24'h0B;
      21'h5C:  return 24'h5C;
      default: return 24'h00;
    endcase
  endfunction

  // Digit value of c, or -1 when c is not a hex digit.
  function automatic int hex_of(logic [20:0] c);
    if (c >= 21'h30 && c <= 21'h39) return int'(c) - 'h30;
    if (c >= 21'h41 && c <= 21'h46) return int'(c) - 'h41 + 10;
    if (c >= 21'h61 && c <= 21'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  // Advances the bench copy of the decoder by one codepoint and returns the
  // result beat that the block must produce for it.
  function automatic token_t decode_step(logic [20:0] c);
    token_t      r;
    logic [23:0] ctl;
    int          hv;
    r = '{mode: MODE_READY, valid: 1'b0, tok: 24'h0, esc: 1'b0};
    case (dec_mode)
      MODE_READY: begin
        if (c == ChBackslash) begin
          dec_mode = MODE_ESC;
        end else begin
          r.valid = 1'b1;
          r.tok   = {3'b000, c};
        end
      end
      MODE_ESC: begin
        ctl = escape_code(c);
        if (ctl != 24'h0) begin
          r.valid  = 1'b1;
          r.tok    = ctl;
          dec_mode = MODE_READY;
        end else if (c == ChLowerU) begin
          dec_mode = MODE_U;
        end else begin
          // Unknown escapes, the null character among them, pass through.
          r.valid  = 1'b1;
          r.tok    = {3'b000, c};
          r.esc    = 1'b1;
          dec_mode = MODE_READY;
        end
      end
      MODE_U: begin
        if (c == ChOpenBrace) begin
          dec_mode   = MODE_PAYLOAD;
          dec_digits = 0;
          dec_accum  = '0;
        end else begin
          dec_mode = MODE_ERR_START;
        end
      end
      MODE_PAYLOAD: begin
        if (c == ChCloseBrace) begin
          r.valid  = 1'b1;
          r.tok    = dec_accum;
          dec_mode = MODE_READY;
        end else if (dec_digits >= MaxDigits) begin
          // Even a valid digit overflows once the payload is full.
          dec_mode = MODE_ERR_LEN;
        end else begin
          hv = hex_of(c);
          dec_digits++;
          if (hv < 0) begin
            dec_mode = MODE_ERR_HEX;
          end else begin
            dec_accum = {dec_accum[19:0], 4'(hv)};
          end
        end
      end
      default: begin
        // Error modes are sticky: nothing changes until reset.
      end
    endcase
    r.mode = dec_mode;
    return r;
  endfunction

  // Idle length in cycles: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random codepoint in range, weighted toward ASCII and the characters
  // that matter to the escape syntax.
  function automatic logic [20:0] rand_codepoint();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3, 4: return 21'($urandom_range('h20, 'h7E));
      5:             return 21'($urandom_range(0, 'h1F));
      6:             return 21'($urandom_range('h80, 'hFFFF));
      7:             return 21'($urandom_range('h10000, 'h10FFFF));
      8: begin
        case ($urandom_range(0, 5))
          0:       return ChBackslash;
          1:       return ChOpenBrace;
          2:       return ChCloseBrace;
          3:       return ChLowerU;
          4:       return 21'h30;
          default: return 21'h46;
        endcase
      end
      default:       return ($urandom_range(0, 1) != 0) ? 21'h10FFFF : 21'h0;
    endcase
  endfunction

  // Hex digit character for value v in a random case.
  function automatic logic [20:0] hex_char(int v);
    if (v < 10) return 21'('h30 + v);
    if ($urandom_range(0, 1) != 0) return 21'('h41 + v - 10);
    return 21'('h61 + v - 10);
  endfunction

  // Offers one beat after a random gap and holds it until it is taken, then
  // records the predicted result.
  task automatic push_char(input logic [20:0] c);
    int gap;
    gap = tx_burst ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, c};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    token_queue.push_back(decode_step(c));
    item_count++;
  endtask

  task automatic push_hex_digits(input int n);
    for (int i = 0; i < n; i++) begin
      push_char(hex_char($urandom_range(0, 15)));
    end
  endtask

  // Result side: random stalls, with phases of steady acceptance.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = rx_burst ? 0 : idle_len();
      if (n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // Compares each accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    token_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (token_queue.size() == 0) begin
        $display("%0t: result beat with nothing expected: tdata=%h tuser=%h",
                 $time, m_axis_tdata, m_axis_tuser);
        fail_count++;
      end else begin
        want = token_queue.pop_front();
        if (m_axis_tuser[2:0] !== want.mode) begin
          $display("%0t: mode_code expected %0d, got %0d",
                   $time, want.mode, m_axis_tuser[2:0]);
          fail_count++;
        end
        if (m_axis_tuser[3] !== want.valid) begin
          $display("%0t: token_valid expected %0d, got %0d",
                   $time, want.valid, m_axis_tuser[3]);
          fail_count++;
        end
        if (m_axis_tdata !== want.tok) begin
          $display("%0t: token_char expected %h, got %h",
                   $time, want.tok, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser[4] !== want.esc) begin
          $display("%0t: escaped_flag expected %0d, got %0d",
                   $time, want.esc, m_axis_tuser[4]);
          fail_count++;
        end
        if (m_axis_tuser[7:5] !== 3'b000) begin
          $display("%0t: tuser pad bits expected 0, got %b",
                   $time, m_axis_tuser[7:5]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("escape_sequence_decoder test failed");
      $finish;
    end
  end

  initial begin
    logic [20:0] c;
    int          pick;
    int          next_shuffle;
    break_kind_t kind;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table. A typed expectation takes the place of the
    // prediction, while the prediction still moves the bench state on.
    foreach (dir_table[i]) begin
      push_char(dir_table[i].ch);
      if (dir_table[i].typed) begin
        token_queue[$] = dir_table[i].want;
      end
    end

    // Random well-formed traffic; no sequence here may reach an error mode.
    next_shuffle = item_count;
    while (item_count < RandomBeats) begin
      if (item_count >= next_shuffle) begin
        tx_burst     = ($urandom_range(0, 3) == 0);
        rx_burst     = ($urandom_range(0, 3) == 0);
        next_shuffle = item_count + 100;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        do c = rand_codepoint(); while (c == ChBackslash);
        push_char(c);
      end else if (pick < 65) begin
        push_char(ChBackslash);
        push_char(EscLetters[$urandom_range(0, 8)]);
      end else if (pick < 75) begin
        push_char(ChBackslash);
        do c = rand_codepoint(); while (escape_code(c) != 24'h0 || c == ChLowerU);
        push_char(c);
      end else begin
        push_char(ChBackslash);
        push_char(ChLowerU);
        push_char(ChOpenBrace);
        push_hex_digits(($urandom_range(0, 3) == 0) ? MaxDigits
                                                    : $urandom_range(0, MaxDigits));
        push_char(ChCloseBrace);
      end
    end

    // One broken u escape, then noise that must keep reporting the error.
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    kind = break_kind_t'($urandom_range(0, 2));
    push_char(ChBackslash);
    push_char(ChLowerU);
    case (kind)
      BREAK_START: begin
        do c = rand_codepoint(); while (c == ChOpenBrace);
        push_char(c);
      end
      BREAK_LEN: begin
        push_char(ChOpenBrace);
        push_hex_digits(MaxDigits);
        do c = rand_codepoint(); while (c == ChCloseBrace);
        push_char(c);
      end
      default: begin
        push_char(ChOpenBrace);
        push_hex_digits($urandom_range(0, MaxDigits - 1));
        do c = rand_codepoint(); while (c == ChCloseBrace || hex_of(c) >= 0);
        push_char(c);
      end
    endcase
    repeat (TailBeats) push_char(rand_codepoint());
    s_axis_tvalid <= 1'b0;

    while (token_queue.size() != 0) @(posedge clk);
    // Allow for a stray beat still in the two-stage pipeline.
    repeat (8) @(posedge clk);

    if (fail_count == 0) begin
      $display("escape_sequence_decoder test passed");
    end else begin
      $display("escape_sequence_decoder test failed");
    end
    $finish;
  end

endmodule
